// ===== rtl/i2p_pkg.sv =====
// Shared types, character constants, operator codes and the sequencer program.
package i2p_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic [1:0] status;
  } out_word_t;

  typedef logic [2:0] code_t;

  localparam code_t CODE_PLUS  = 3'd0;
  localparam code_t CODE_MINUS = 3'd1;
  localparam code_t CODE_MUL   = 3'd2;
  localparam code_t CODE_DIV   = 3'd3;
  localparam code_t CODE_OPEN  = 3'd4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNMATCHED = 2'd2;

  // Status of the operator stack as seen by the sequencer.
  typedef struct packed {
    logic  empty;
    logic  full;
    code_t top;
  } stk_status_t;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_OP_LOOP,
    STEP_OPEN,
    STEP_CL_LOOP,
    STEP_CL_CHK,
    STEP_EMIT_IN,
    STEP_END
  } step_e;

  typedef enum logic [2:0] {
    COND_NO_INPUT,
    COND_OP_STOP,
    COND_CL_STOP,
    COND_EMPTY,
    COND_FLUSH_DONE,
    COND_ALWAYS
  } cond_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_POP_EMIT,
    ACT_POP,
    ACT_PUSH,
    ACT_EMIT_IN,
    ACT_ERR_CLOSE,
    ACT_FINISH
  } act_e;

  // One control word: the condition picks which action and successor apply.
  typedef struct packed {
    cond_e cond;
    act_e  act_t;
    step_e nxt_t;
    act_e  act_f;
    step_e nxt_f;
    logic  dispatch_f;
  } ctl_word_t;

  function automatic ctl_word_t ctl_rom(input step_e step);
    ctl_word_t cw;
    unique case (step)
      STEP_IDLE:    cw = '{COND_NO_INPUT,   ACT_NONE,      STEP_IDLE,
                           ACT_ACCEPT,      STEP_IDLE,     1'b1};
      STEP_OP_LOOP: cw = '{COND_OP_STOP,    ACT_PUSH,      STEP_END,
                           ACT_POP_EMIT,    STEP_OP_LOOP,  1'b0};
      STEP_OPEN:    cw = '{COND_ALWAYS,     ACT_PUSH,      STEP_END,
                           ACT_NONE,        STEP_END,      1'b0};
      STEP_CL_LOOP: cw = '{COND_CL_STOP,    ACT_NONE,      STEP_CL_CHK,
                           ACT_POP_EMIT,    STEP_CL_LOOP,  1'b0};
      STEP_CL_CHK:  cw = '{COND_EMPTY,      ACT_ERR_CLOSE, STEP_END,
                           ACT_POP,         STEP_END,      1'b0};
      STEP_EMIT_IN: cw = '{COND_ALWAYS,     ACT_EMIT_IN,   STEP_END,
                           ACT_NONE,        STEP_END,      1'b0};
      STEP_END:     cw = '{COND_FLUSH_DONE, ACT_FINISH,    STEP_IDLE,
                           ACT_POP_EMIT,    STEP_END,      1'b0};
      default:      cw = '{COND_ALWAYS,     ACT_NONE,      STEP_IDLE,
                           ACT_NONE,        STEP_IDLE,     1'b0};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    unique case (code)
      CODE_PLUS:  ch = CHAR_PLUS;
      CODE_MINUS: ch = CHAR_MINUS;
      CODE_MUL:   ch = CHAR_MUL;
      CODE_DIV:   ch = CHAR_DIV;
      CODE_OPEN:  ch = CHAR_OPEN;
      default:    ch = CHAR_PLUS;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input code_t code);
    logic [1:0] p;
    unique case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_OPEN:             p = 2'd0;
      default:               p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/i2p_stack.sv =====
// Operator stack: entry memory, fill count and a registered top-of-stack read.
module i2p_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  i2p_pkg::code_t       push_code_i,
  output i2p_pkg::stk_status_t status_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  i2p_pkg::code_t mem [STACK_DEPTH];

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  rd_full;
  logic [AW-1:0]  wr_addr, rd_addr;
  i2p_pkg::code_t rd_q;
  logic           byp_q;
  i2p_pkg::code_t byp_data_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // The read port always fetches the entry that will be on top next cycle.
  // A push writes exactly that address, so its data is forwarded instead.
  assign rd_full = (cnt_d == '0) ? '0 : cnt_d - CW'(1);
  assign rd_addr = rd_full[AW-1:0];
  assign wr_addr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_addr] <= push_code_i;
    end
    rd_q       <= mem[rd_addr];
    byp_data_q <= push_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      byp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      byp_q <= push_i;
    end
  end

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CW'(STACK_DEPTH));
  assign status_o.top   = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter: microcoded sequencer over an operator stack.
// The sequencer takes no new item until the current one has run through its steps and
// returned to idle; each stack entry it emits takes a step, and output stalls hold it.
// Each word of an item waits in a pending slot; the last one leaves once the finish step
// runs, through the pending slot and an output register.
// Reset clears the sequencer, the stack count and the output; stack memory is not cleared.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2p_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2p_pkg::out_word_t  out_word_o
);

  // Sequencer state: the step register plays the role of the program counter.
  i2p_pkg::step_e step_q, step_d;

  // Latched input word and its operator code.
  logic [7:0]     char_q;
  logic           end_q;
  i2p_pkg::code_t code_q;

  // A word is held back in the pending slot until we know whether another one
  // follows; only then can its last_of_run flag be set correctly.
  logic             pend_v_q, pend_v_d;
  logic [7:0]       pend_char_q, pend_char_d;
  logic [1:0]       pend_status_q, pend_status_d;

  logic               out_v_q, out_v_d;
  i2p_pkg::out_word_t out_q, out_d;

  i2p_pkg::ctl_word_t   cw;
  i2p_pkg::stk_status_t stk;
  i2p_pkg::act_e        act;
  i2p_pkg::step_e       nxt;
  i2p_pkg::step_e       dispatch_step;
  i2p_pkg::code_t       in_code;

  logic       cond_val;
  logic       prec_ok;
  logic       emit_req;
  logic       rel_req;
  logic       slot_free;
  logic       hold;
  logic       do_push;
  logic       do_pop;
  logic       accept;
  logic [7:0] emit_char;
  logic [1:0] emit_status;

  i2p_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (do_push),
    .pop_i      (do_pop),
    .push_code_i(code_q),
    .status_o   (stk)
  );

  assign cw = i2p_pkg::ctl_rom(step_q);

  // Classify the arriving character; the idle step jumps straight to its handler.
  always_comb begin
    in_code       = i2p_pkg::CODE_OPEN;
    dispatch_step = i2p_pkg::STEP_EMIT_IN;
    unique case (in_word_i.in_char)
      i2p_pkg::CHAR_PLUS: begin
        in_code       = i2p_pkg::CODE_PLUS;
        dispatch_step = i2p_pkg::STEP_OP_LOOP;
      end
      i2p_pkg::CHAR_MINUS: begin
        in_code       = i2p_pkg::CODE_MINUS;
        dispatch_step = i2p_pkg::STEP_OP_LOOP;
      end
      i2p_pkg::CHAR_MUL: begin
        in_code       = i2p_pkg::CODE_MUL;
        dispatch_step = i2p_pkg::STEP_OP_LOOP;
      end
      i2p_pkg::CHAR_DIV: begin
        in_code       = i2p_pkg::CODE_DIV;
        dispatch_step = i2p_pkg::STEP_OP_LOOP;
      end
      i2p_pkg::CHAR_OPEN:  dispatch_step = i2p_pkg::STEP_OPEN;
      i2p_pkg::CHAR_CLOSE: dispatch_step = i2p_pkg::STEP_CL_LOOP;
      i2p_pkg::CHAR_NUL:   dispatch_step = i2p_pkg::STEP_END;
      default:             dispatch_step = i2p_pkg::STEP_EMIT_IN;
    endcase
  end

  // An incoming operator pops while the top binds at least as tightly.
  assign prec_ok = i2p_pkg::code_prec(code_q) <= i2p_pkg::code_prec(stk.top);

  always_comb begin
    unique case (cw.cond)
      i2p_pkg::COND_NO_INPUT:   cond_val = !in_valid_i;
      i2p_pkg::COND_OP_STOP:    cond_val = stk.empty || !prec_ok;
      i2p_pkg::COND_CL_STOP:    cond_val = stk.empty || (stk.top == i2p_pkg::CODE_OPEN);
      i2p_pkg::COND_EMPTY:      cond_val = stk.empty;
      i2p_pkg::COND_FLUSH_DONE: cond_val = stk.empty || !end_q;
      i2p_pkg::COND_ALWAYS:     cond_val = 1'b1;
      default:                  cond_val = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_val) begin
      act = cw.act_t;
      nxt = cw.nxt_t;
    end else begin
      act = cw.act_f;
      nxt = cw.dispatch_f ? dispatch_step : cw.nxt_f;
    end
  end

  // Word produced by this step, if any. A push onto a full stack turns into
  // an overflow word and the operator is dropped.
  always_comb begin
    emit_req    = 1'b0;
    emit_char   = i2p_pkg::CHAR_NUL;
    emit_status = i2p_pkg::STATUS_OK;
    unique case (act)
      i2p_pkg::ACT_POP_EMIT: begin
        emit_req  = 1'b1;
        emit_char = i2p_pkg::code_char(stk.top);
      end
      i2p_pkg::ACT_EMIT_IN: begin
        emit_req  = 1'b1;
        emit_char = char_q;
      end
      i2p_pkg::ACT_ERR_CLOSE: begin
        emit_req    = 1'b1;
        emit_status = i2p_pkg::STATUS_UNMATCHED;
      end
      i2p_pkg::ACT_PUSH: begin
        emit_req    = stk.full;
        emit_status = i2p_pkg::STATUS_OVERFLOW;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // A new word or the finish step pushes the pending word into the output
  // register, and the step waits while that register is occupied and the output stalls.
  assign rel_req   = (emit_req || (act == i2p_pkg::ACT_FINISH)) && pend_v_q;
  assign slot_free = !out_v_q || !out_stall_i;
  assign hold      = rel_req && !slot_free;

  assign do_push = !hold && (act == i2p_pkg::ACT_PUSH) && !stk.full;
  assign do_pop  = !hold && ((act == i2p_pkg::ACT_POP_EMIT) || (act == i2p_pkg::ACT_POP));
  assign accept  = (act == i2p_pkg::ACT_ACCEPT);

  always_comb begin
    step_d        = hold ? step_q : nxt;
    pend_v_d      = pend_v_q;
    pend_char_d   = pend_char_q;
    pend_status_d = pend_status_q;
    out_v_d       = out_v_q && out_stall_i;
    out_d         = out_q;

    if (!hold) begin
      if (rel_req) begin
        out_v_d           = 1'b1;
        out_d.out_char    = pend_char_q;
        out_d.status      = pend_status_q;
        out_d.last_of_run = (act == i2p_pkg::ACT_FINISH);
      end
      if (emit_req) begin
        pend_v_d      = 1'b1;
        pend_char_d   = emit_char;
        pend_status_d = emit_status;
      end else if (act == i2p_pkg::ACT_FINISH) begin
        pend_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= i2p_pkg::STEP_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      step_q   <= step_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_word_i.in_char;
      end_q  <= in_word_i.end_of_expr;
      code_q <= in_code;
    end
    pend_char_q   <= pend_char_d;
    pend_status_q <= pend_status_d;
    out_q         <= out_d;
  end

  // The sequencer takes a new word only in its idle step.
  assign in_stall_o  = (step_q != i2p_pkg::STEP_IDLE);
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule
